// ===== sv/fvs_pkg.sv =====
// Shared constants, codes and the queue entry type of the vector field sampler.
package fvs_pkg;

  localparam int MAX_DIM   = 32;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int HALF_W    = IDX_W - 1;
  localparam int BANKS     = 8;
  localparam int BANK_AW   = 3 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int VEC_W     = 3 * DATA_W;
  localparam int SIZE_W    = 6;
  localparam int PROD_W    = 64;
  localparam int GRID_W    = PROD_W - FRAC_BITS;
  localparam int CELL_W    = GRID_W - FRAC_BITS;
  localparam int LPROD_W   = DATA_W + FRAC_BITS + 1;
  localparam int ACC_W     = LPROD_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [FRAC_BITS:0]  FX_ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]    FX_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SIZE_W-1:0]   DIM_MAX = SIZE_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_INV_X  = 3'd3,
    CFG_INV_Y  = 3'd4,
    CFG_INV_Z  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // One classified item. Axis 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    cmd_e                            cmd;
    logic [2:0][IDX_W-1:0]           idx0;  // base cell low bits, or write cell
    logic [2:0][IDX_W-1:0]           idx1;  // base cell plus one, low bits
    logic [2:0]                      vld0;
    logic [2:0]                      vld1;
    logic [2:0][FRAC_BITS-1:0]       frac;
    logic [2:0][DATA_W-1:0]          vel;
  } fvs_job_t;

endpackage

// ===== sv/trilinear_vector_field_sampler_unit.sv =====
// Top level of the trilinear vector field sampler.
//
// Usage: drive an item with start high; it is taken at a rising edge where
// busy is low. cmd_i = write stores vel_x/y/z_i at voxel cell_x/y/z_i and
// gives no result. cmd_i = sample interpolates the stored field at
// pos_x/y/z_i (Q16.16 world units, scaled by the inverse spacing registers).
// Each sample yields one result on interp_x/y/z_o, marked by out_valid_o for
// exactly one cycle; the receiver cannot stall, so results flow straight out.
// Throughput: one item per cycle while busy is low; the voxel store is split
// into eight banks by coordinate parity, so all eight neighbours are read in
// the same cycle. busy rises only if the queue between front and back could
// overflow, which the back end, draining one item a cycle, never lets happen.
// Configuration: write registers through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle. Reset restores sizes to 32 and inverse spacing to 1.0; the voxel store
// keeps no reset value and must be written before it is sampled.
module trilinear_vector_field_sampler_unit
  import fvs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd_i,
  input  logic [4:0]            cell_x_i,
  input  logic [4:0]            cell_y_i,
  input  logic [4:0]            cell_z_i,
  input  logic signed [31:0]    vel_x_i,
  input  logic signed [31:0]    vel_y_i,
  input  logic signed [31:0]    vel_z_i,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    pos_z_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  out_valid_o,
  output logic signed [31:0]    interp_x_o,
  output logic signed [31:0]    interp_y_o,
  output logic signed [31:0]    interp_z_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic [2:0][SIZE_W-1:0]  size_q;
  logic [2:0][DATA_W-1:0]  inv_q;

  logic                    accept;
  logic                    q_push, q_pop, q_empty;
  logic [CNT_W-1:0]        q_count;
  fvs_job_t                f_job, b_job;
  logic [2:0][DATA_W-1:0]  interp;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= {3{DIM_MAX}};
      inv_q  <= {3{DATA_W'(FX_ONE)}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIZE_X: size_q[0] <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Y: size_q[1] <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_Z: size_q[2] <= cfg_data_i[SIZE_W-1:0];
        CFG_INV_X:  inv_q[0]  <= cfg_data_i;
        CFG_INV_Y:  inv_q[1]  <= cfg_data_i;
        CFG_INV_Z:  inv_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off new items while the queue plus the item in the front stage
  // could fill it.
  assign busy   = ((CNT_W+1)'(q_count) + (CNT_W+1)'(q_push))
                  >= (CNT_W+1)'(QUEUE_DEPTH);
  assign accept = start && !busy;

  fvs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_e'(cmd_i)),
    .cell_i   ({cell_z_i, cell_y_i, cell_x_i}),
    .vel_i    ({vel_z_i, vel_y_i, vel_x_i}),
    .pos_i    ({pos_z_i, pos_y_i, pos_x_i}),
    .size_i   (size_q),
    .inv_i    (inv_q),
    .push_o   (q_push),
    .job_o    (f_job)
  );

  fvs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (f_job),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .count_o (q_count),
    .job_o   (b_job)
  );

  fvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (b_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .interp_o    (interp)
  );

  assign interp_x_o = interp[0];
  assign interp_y_o = interp[1];
  assign interp_z_o = interp[2];

  // The queue must never take an item while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count != CNT_W'(QUEUE_DEPTH)))
    else $error("item pushed into a full queue");

  // Every accepted sample must be followed by its result.
  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_SAMPLE) |-> ##9 out_valid_o)
    else $error("sample result missing");

  // A write never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_WRITE) |-> ##9 !out_valid_o)
    else $error("write produced a result");

endmodule

// ===== sv/fvs_ram.sv =====
// Generic single-port RAM with registered read.
module fvs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fvs_lerp.sv =====
// Two-stage linear blend a*(1-f) + b*f, rounded and saturated.
module fvs_lerp
  import fvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic [DATA_W-1:0]    a_i,
  input  logic [DATA_W-1:0]    b_i,
  input  logic [FRAC_BITS-1:0] f_i,
  output logic [DATA_W-1:0]    y_o
);

  logic [FRAC_BITS:0]        wf;
  logic signed [LPROD_W-1:0] pa_d, pb_d, pa_q, pb_q;
  logic signed [ACC_W-1:0]   acc, sh;
  logic [ACC_W-DATA_W:0]     hi;
  logic [DATA_W-1:0]         y_d, y_q;

  always_comb begin
    wf   = FX_ONE - {1'b0, f_i};
    pa_d = $signed(a_i) * $signed({1'b0, wf});
    pb_d = $signed(b_i) * $signed({2'b00, f_i});
  end

  // Round by adding one half, floor shift, then clamp to the signed 32-bit range.
  always_comb begin
    acc = ACC_W'(pa_q) + ACC_W'(pb_q) + $signed(FX_HALF);
    sh  = acc >>> FRAC_BITS;
    hi  = sh[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      y_d = sh[DATA_W-1:0];
    end else if (sh[ACC_W-1]) begin
      y_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    pb_q <= pb_d;
    y_q  <= y_d;
  end

  assign y_o = y_q;

endmodule

// ===== sv/fvs_front.sv =====
// Front end: accept items, scale positions and classify neighbour cells.
module fvs_front
  import fvs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  cmd_e                         cmd_i,
  input  logic [2:0][IDX_W-1:0]        cell_i,
  input  logic [2:0][DATA_W-1:0]       vel_i,
  input  logic [2:0][DATA_W-1:0]       pos_i,
  input  logic [2:0][SIZE_W-1:0]       size_i,
  input  logic [2:0][DATA_W-1:0]       inv_i,
  output logic                         push_o,
  output fvs_job_t                     job_o
);

  logic                      vld_q;
  cmd_e                      cmd_q;
  logic [2:0][IDX_W-1:0]     cell_q;
  logic [2:0][DATA_W-1:0]    vel_q;
  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];

  logic [GRID_W-1:0]         g    [3];
  logic [CELL_W-1:0]         base [3];
  logic [CELL_W:0]           c1   [3];
  logic [SIZE_W-1:0]         eff  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a] = $signed(pos_i[a]) * $signed({1'b0, inv_i[a]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q  <= cmd_i;
      cell_q <= cell_i;
      vel_q  <= vel_i;
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= prod_d[a];
      end
    end
  end

  // Cell truncates toward zero, fraction comes from the floor.
  always_comb begin
    job_o     = '0;
    job_o.cmd = cmd_q;
    job_o.vel = vel_q;
    for (int a = 0; a < 3; a++) begin
      g[a]    = prod_q[a][PROD_W-1:FRAC_BITS];
      base[a] = g[a][GRID_W-1:FRAC_BITS]
                + CELL_W'(g[a][GRID_W-1] && (g[a][FRAC_BITS-1:0] != '0));
      c1[a]   = {base[a][CELL_W-1], base[a]} + (CELL_W+1)'(1);
      eff[a]  = (size_i[a] > DIM_MAX) ? DIM_MAX : size_i[a];
      job_o.frac[a] = g[a][FRAC_BITS-1:0];
      job_o.vld0[a] = !base[a][CELL_W-1] && (base[a] < CELL_W'(eff[a]));
      job_o.vld1[a] = !c1[a][CELL_W] && (c1[a] < (CELL_W+1)'(eff[a]));
      job_o.idx1[a] = c1[a][IDX_W-1:0];
      job_o.idx0[a] = (cmd_q == CMD_WRITE) ? cell_q[a] : base[a][IDX_W-1:0];
    end
  end

  assign push_o = vld_q;

endmodule

// ===== sv/fvs_queue.sv =====
// Short queue of classified items between front and back.
module fvs_queue
  import fvs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  fvs_job_t                    job_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output fvs_job_t                    job_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  fvs_job_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign job_o   = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== sv/fvs_back.sv =====
// Back end: banked voxel store and the three-level blend pipeline.
module fvs_back
  import fvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  fvs_job_t                job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output logic [2:0][DATA_W-1:0]  interp_o
);

  logic [BANKS-1:0]              we;
  logic [BANKS-1:0][BANK_AW-1:0] addr;
  logic [BANKS-1:0][VEC_W-1:0]   rdata;
  logic [2:0]                    wbank;
  logic [2:0][IDX_W-1:0]         sel [BANKS];
  logic [BANKS-1:0]              nv_d;

  logic [7:1]                    smp_q;
  logic [2:0]                    par_q;
  logic [BANKS-1:0]              nv_q;
  logic [FRAC_BITS-1:0]          fx_q;
  logic [FRAC_BITS-1:0]          fy_q [1:3];
  logic [FRAC_BITS-1:0]          fz_q [1:5];

  logic [DATA_W-1:0]             nb [BANKS][3];
  logic [DATA_W-1:0]             ex [4][3];
  logic [DATA_W-1:0]             py [2][3];

  assign pop_o = !empty_i;
  assign wbank = {job_i.idx0[2][0], job_i.idx0[1][0], job_i.idx0[0][0]};

  // Each bank holds one parity class, so the eight neighbours never collide.
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      for (int a = 0; a < 3; a++) begin
        sel[b][a] = (job_i.idx0[a][0] == b[a]) ? job_i.idx0[a] : job_i.idx1[a];
      end
      addr[b] = {sel[b][2][IDX_W-1:1], sel[b][1][IDX_W-1:1], sel[b][0][IDX_W-1:1]};
      we[b]   = pop_o && (job_i.cmd == CMD_WRITE) && (wbank == 3'(b));
      nv_d[b] = (b[0] ? job_i.vld1[0] : job_i.vld0[0])
              && (b[1] ? job_i.vld1[1] : job_i.vld0[1])
              && (b[2] ? job_i.vld1[2] : job_i.vld0[2]);
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    fvs_ram #(
      .WIDTH (VEC_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[b]),
      .addr_i  (addr[b]),
      .wdata_i (job_i.vel),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else begin
      smp_q <= {smp_q[6:1], pop_o && (job_i.cmd == CMD_SAMPLE)};
    end
  end

  always_ff @(posedge clk_i) begin
    par_q    <= wbank;
    nv_q     <= nv_d;
    fx_q     <= job_i.frac[0];
    fy_q[1]  <= job_i.frac[1];
    fz_q[1]  <= job_i.frac[2];
    for (int i = 2; i <= 3; i++) begin
      fy_q[i] <= fy_q[i-1];
    end
    for (int i = 2; i <= 5; i++) begin
      fz_q[i] <= fz_q[i-1];
    end
  end

  // Map neighbour {dz,dy,dx} to its bank; drop neighbours outside the grid.
  always_comb begin
    for (int n = 0; n < BANKS; n++) begin
      for (int c = 0; c < 3; c++) begin
        nb[n][c] = nv_q[n] ? rdata[3'(n) ^ par_q][c*DATA_W +: DATA_W] : '0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_comp
    for (genvar e = 0; e < 4; e++) begin : g_lx
      fvs_lerp u_lerp (
        .clk_i (clk_i),
        .a_i   (nb[2*e][c]),
        .b_i   (nb[2*e+1][c]),
        .f_i   (fx_q),
        .y_o   (ex[e][c])
      );
    end
    for (genvar p = 0; p < 2; p++) begin : g_ly
      fvs_lerp u_lerp (
        .clk_i (clk_i),
        .a_i   (ex[2*p][c]),
        .b_i   (ex[2*p+1][c]),
        .f_i   (fy_q[3]),
        .y_o   (py[p][c])
      );
    end
    fvs_lerp u_lz (
      .clk_i (clk_i),
      .a_i   (py[0][c]),
      .b_i   (py[1][c]),
      .f_i   (fz_q[5]),
      .y_o   (interp_o[c])
    );
  end

  assign out_valid_o = smp_q[7];

endmodule

// ===== sim/fvs_checker.sv =====
// Checker of the vector field sampler: tracks writes, predicts samples and compares results.
module fvs_checker
  import fvs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cmd_i,
  input  logic [4:0]         cell_x_i,
  input  logic [4:0]         cell_y_i,
  input  logic [4:0]         cell_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic signed [31:0] interp_x_i,
  input  logic signed [31:0] interp_y_i,
  input  logic signed [31:0] interp_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [31:0] v[3];
  } velocity_t;

  logic signed [31:0] field_mem [0:MAX_DIM*MAX_DIM*MAX_DIM-1][3];
  logic [5:0]         grid_size [3];
  logic [31:0]        inv_spacing [3];
  velocity_t          expected_q [$];
  int                 mismatches = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    longint acc;
    acc = a * (65536 - f) + b * f + 32768;
    return clip32(acc >>> FRAC_BITS);
  endfunction

  function automatic longint voxel(longint x, longint y, longint z, int c);
    longint lim[3];
    for (int a = 0; a < 3; a++)
      lim[a] = (grid_size[a] > MAX_DIM) ? MAX_DIM : grid_size[a];
    if (x < 0 || y < 0 || z < 0) return 0;
    if (x >= lim[0] || y >= lim[1] || z >= lim[2]) return 0;
    return field_mem[x + MAX_DIM * (y + MAX_DIM * z)][c];
  endfunction

  function automatic velocity_t sample_field(logic signed [31:0] p[3]);
    velocity_t r;
    longint g, base[3], fr[3], e00, e10, e01, e11, p0, p1;
    for (int a = 0; a < 3; a++) begin
      g = (longint'(p[a]) * longint'({32'b0, inv_spacing[a]})) >>> FRAC_BITS;
      fr[a] = g & 64'hFFFF;
      // cell truncates toward zero, the fraction follows the floor
      base[a] = (g >= 0) ? (g >>> FRAC_BITS) : -((-g) >>> FRAC_BITS);
    end
    for (int c = 0; c < 3; c++) begin
      e00 = blend(voxel(base[0], base[1], base[2], c),
                  voxel(base[0] + 1, base[1], base[2], c), fr[0]);
      e10 = blend(voxel(base[0], base[1] + 1, base[2], c),
                  voxel(base[0] + 1, base[1] + 1, base[2], c), fr[0]);
      e01 = blend(voxel(base[0], base[1], base[2] + 1, c),
                  voxel(base[0] + 1, base[1], base[2] + 1, c), fr[0]);
      e11 = blend(voxel(base[0], base[1] + 1, base[2] + 1, c),
                  voxel(base[0] + 1, base[1] + 1, base[2] + 1, c), fr[0]);
      p0 = blend(e00, e10, fr[1]);
      p1 = blend(e01, e11, fr[1]);
      r.v[c] = 32'(blend(p0, p1, fr[2]));
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();
  assign fail_count_o = mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] pos[3];
    velocity_t got, want;
    bit bad;
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        grid_size[a] = 6'd32;
        inv_spacing[a] = 32'd65536;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIZE_X: grid_size[0] = cfg_data_i[5:0];
          CFG_SIZE_Y: grid_size[1] = cfg_data_i[5:0];
          CFG_SIZE_Z: grid_size[2] = cfg_data_i[5:0];
          CFG_INV_X:  inv_spacing[0] = cfg_data_i;
          CFG_INV_Y:  inv_spacing[1] = cfg_data_i;
          CFG_INV_Z:  inv_spacing[2] = cfg_data_i;
          default: ;
        endcase
      end
      // compare the result first: a result never comes from this edge's item
      if (out_valid_i) begin
        got.v[0] = interp_x_i;
        got.v[1] = interp_y_i;
        got.v[2] = interp_z_i;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %h %h %h", got.v[0], got.v[1], got.v[2]);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          bad = 0;
          for (int c = 0; c < 3; c++)
            if (got.v[c] !== want.v[c]) bad = 1;
          if (bad) begin
            if (mismatches < 10)
              $display("mismatch: expected %h %h %h, got %h %h %h",
                       want.v[0], want.v[1], want.v[2], got.v[0], got.v[1], got.v[2]);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_WRITE) begin
          field_mem[cell_x_i + MAX_DIM * (cell_y_i + MAX_DIM * cell_z_i)][0] = vel_x_i;
          field_mem[cell_x_i + MAX_DIM * (cell_y_i + MAX_DIM * cell_z_i)][1] = vel_y_i;
          field_mem[cell_x_i + MAX_DIM * (cell_y_i + MAX_DIM * cell_z_i)][2] = vel_z_i;
        end else begin
          pos[0] = pos_x_i;
          pos[1] = pos_y_i;
          pos[2] = pos_z_i;
          expected_q.insert(expected_q.size(), sample_field(pos));
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives the vector field sampler and gives the verdict.
module tb;
  import fvs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd = CMD_WRITE;
  logic [4:0]         cell_idx[3] = '{default: '0};
  logic signed [31:0] vel[3] = '{default: '0};
  logic signed [31:0] pos[3] = '{default: '0};
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = CFG_SIZE_X;
  logic [31:0]        cfg_data = '0;
  logic               out_valid;
  logic signed [31:0] interp[3];
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  int                 burst_left = 0;
  bit                 no_gaps = 0;
  int unsigned        size_now[3];
  logic [31:0]        inv_now[3];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trilinear_vector_field_sampler_unit uut (
    .clk_i, .rst_ni, .start, .busy,
    .cmd_i(cmd), .cell_x_i(cell_idx[0]), .cell_y_i(cell_idx[1]), .cell_z_i(cell_idx[2]),
    .vel_x_i(vel[0]), .vel_y_i(vel[1]), .vel_z_i(vel[2]),
    .pos_x_i(pos[0]), .pos_y_i(pos[1]), .pos_z_i(pos[2]),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid),
    .interp_x_o(interp[0]), .interp_y_o(interp[1]), .interp_z_o(interp[2])
  );

  fvs_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .cell_x_i(cell_idx[0]), .cell_y_i(cell_idx[1]), .cell_z_i(cell_idx[2]),
    .vel_x_i(vel[0]), .vel_y_i(vel[1]), .vel_z_i(vel[2]),
    .pos_x_i(pos[0]), .pos_y_i(pos[1]), .pos_z_i(pos[2]),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid),
    .interp_x_i(interp[0]), .interp_y_i(interp[1]), .interp_z_i(interp[2]),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold the item until taken. busy is read at the falling edge, where it is stable.
  task automatic offer(logic c, logic [4:0] cl[3], logic signed [31:0] v[3],
                       logic signed [31:0] p[3]);
    bit taken;
    if (!no_gaps && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    cmd <= c;
    for (int a = 0; a < 3; a++) begin
      cell_idx[a] <= cl[a];
      vel[a] <= v[a];
      pos[a] <= p[a];
    end
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    if (burst_left > 0) burst_left--;
  endtask

  // Random velocity, with the extremes now and then.
  function automatic logic signed [31:0] pick_vel();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sh00010000 : 32'shFFFF0000;
      default: return $urandom;
    endcase
  endfunction

  // Position that lands near the grid in use once scaled; sometimes anywhere.
  function automatic logic signed [31:0] pick_pos(int a);
    longint t, p;
    int unsigned lim;
    lim = (size_now[a] == 0) ? 2 : ((size_now[a] > MAX_DIM) ? MAX_DIM : size_now[a]);
    if (inv_now[a] == 0 || $urandom_range(0, 4) == 0) return $urandom;
    t = longint'($urandom_range(0, (lim + 2) * 65536)) - 65536;
    p = (t * 65536) / longint'({32'b0, inv_now[a]});
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return 32'(p);
  endfunction

  task automatic write_voxel(int x, int y, int z);
    logic [4:0] cl[3];
    logic signed [31:0] v[3];
    logic signed [31:0] p[3];
    cl[0] = 5'(x);
    cl[1] = 5'(y);
    cl[2] = 5'(z);
    for (int a = 0; a < 3; a++) begin
      v[a] = pick_vel();
      p[a] = $urandom;
    end
    offer(CMD_WRITE, cl, v, p);
  endtask

  task automatic sample_at(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz);
    logic [4:0] cl[3];
    logic signed [31:0] v[3];
    logic signed [31:0] p[3];
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int a = 0; a < 3; a++) begin
      cl[a] = $urandom;
      v[a] = $urandom;
    end
    offer(CMD_SAMPLE, cl, v, p);
  endtask

  // Wait until every result is in, then let the pipeline settle; only then touch registers.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leave the write enable high; the caller drops it after the last write.
  task automatic set_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Apply a grid setting and fill every voxel that a sample can read.
  task automatic setup_grid(int unsigned sx, int unsigned sy, int unsigned sz,
                            logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    int unsigned lim[3];
    size_now = '{sx, sy, sz};
    inv_now = '{ix, iy, iz};
    set_reg(CFG_SIZE_X, sx);
    set_reg(CFG_SIZE_Y, sy);
    set_reg(CFG_SIZE_Z, sz);
    set_reg(CFG_INV_X, ix);
    set_reg(CFG_INV_Y, iy);
    set_reg(CFG_INV_Z, iz);
    cfg_we <= 1'b0;
    for (int a = 0; a < 3; a++)
      lim[a] = (size_now[a] > MAX_DIM) ? MAX_DIM : size_now[a];
    for (int z = 0; z < lim[2]; z++)
      for (int y = 0; y < lim[1]; y++)
        for (int x = 0; x < lim[0]; x++)
          write_voxel(x, y, z);
  endtask

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd65536;
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  initial begin
    int unsigned s[3];
    logic [31:0] iv[3];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small grid, unit spacing, extreme positions and edges.
    no_gaps = 1;
    set_reg(cfg_idx_e'(3'(CFG_INV_Z) + 3'd1), 32'hFFFFFFFF);  // unmapped index, dropped
    setup_grid(2, 2, 2, 32'd65536, 32'd65536, 32'd65536);
    write_voxel(31, 31, 31);  // beyond the grid in use
    write_voxel(0, 0, 0);
    sample_at(32'sh0, 32'sh0, 32'sh0);
    sample_at(32'sh00008000, 32'sh00008000, 32'sh00008000);
    sample_at(32'sh00010000, 32'sh00010000, 32'sh00010000);  // last point, neighbours out
    sample_at(-32'sh1, -32'sh1, -32'sh1);                    // just below zero
    sample_at(-32'sh00018000, 32'sh00004000, 32'sh0000C000); // negative base cell
    sample_at(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    sample_at(32'sh80000000, 32'sh80000000, 32'sh80000000);
    sample_at(32'sh0000FFFF, 32'sh00000001, 32'sh00020000);
    drain();
    no_gaps = 0;

    for (int ph = 0; ph < 26; ph++) begin
      for (int a = 0; a < 3; a++) begin
        s[a] = $urandom_range(1, 4);
        iv[a] = pick_inv();
      end
      case (ph)
        0: s = '{32, 1, 1};
        1: s = '{1, 32, 1};
        2: s = '{1, 1, 32};
        3: s = '{63, 1, 2};                // above the maximum acts as the maximum
        4: s = '{0, 4, 3};                 // empty axis gives zero everywhere
        5: iv = '{32'd1, 32'd1, 32'd1};
        6: iv = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        7: iv = '{32'd0, 32'd0, 32'd0};    // zero spacing pins cell 0
        8: s = '{2, 63, 63} ;
        default: ;
      endcase
      if (ph == 8) s = '{1, 1, 1};
      no_gaps = (ph % 5 == 1);
      setup_grid(s[0], s[1], s[2], iv[0], iv[1], iv[2]);
      repeat (20) begin
        if ($urandom_range(0, 9) == 0)
          write_voxel($urandom, $urandom, $urandom);
        else
          sample_at(pick_pos(0), pick_pos(1), pick_pos(2));
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fvs_pkg.sv
sv/fvs_ram.sv
sv/fvs_lerp.sv
sv/fvs_front.sv
sv/fvs_queue.sv
sv/fvs_back.sv
sv/trilinear_vector_field_sampler_unit.sv
sim/fvs_checker.sv
sim/tb.sv
